// File: hw/rtl/linear_key_value_table_defines.svh
// assertion macros for the key-value table
// all of them sample on clk_i and are switched off while rst_ni is low
`ifndef LINEAR_KEY_VALUE_TABLE_DEFINES_SVH
`define LINEAR_KEY_VALUE_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

// plain property check
`define LKVT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lkvt assertion failed");

// same-cycle implication
`define LKVT_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lkvt implication failed");

// next-cycle implication
`define LKVT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lkvt next-cycle implication failed");

`else

`define LKVT_ASSERT(lbl, prop)
`define LKVT_ASSERT_IMPL(lbl, ante, cons)
`define LKVT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: hw/rtl/lkvt_pkg.sv
package lkvt_pkg;

  // operation codes
  typedef enum logic [0:0] {
    OP_GET = 1'b0,
    OP_SET = 1'b1
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_ZERO_KEY = 2'd2
  } status_e;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 5;

  // request item
  typedef struct packed {
    op_e               op;
    logic [KeyW-1:0]   key;
    logic [ValueW-1:0] value;
  } in_t;

  // result item
  typedef struct packed {
    logic [ValueW-1:0] read_value;
    logic              found;
    status_e           status;
    logic [CountW-1:0] entry_count_out;
  } out_t;

endpackage

// File: hw/rtl/linear_key_value_table.sv
// Lookup: with n stored pairs, a lookup issues one memory read per cycle over at most n
// entries, and the result is registered once a hit or the last entry has been compared.
// A new item is taken only after the previous result is registered, as the key/value
// memories each have a single read port; a zero key or an empty table skips the scan.
// Reset: the entry count and all control state clear at once; memory contents are left
// as they are, as only entries below the count are ever read. No clearing pass.
`include "linear_key_value_table_defines.svh"

module linear_key_value_table #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lkvt_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output lkvt_pkg::out_t out_data_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);
  localparam int unsigned ExtW = CntW + lkvt_pkg::CountW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  // key and value memories
  logic [lkvt_pkg::KeyW-1:0]   key_mem [ENTRIES];
  logic [lkvt_pkg::ValueW-1:0] val_mem [ENTRIES];
  logic [lkvt_pkg::KeyW-1:0]   key_rd_q;
  logic [lkvt_pkg::ValueW-1:0] val_rd_q;

  // control state
  state_e          state_q;
  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] scan_idx_q;
  logic [IdxW-1:0] rd_idx_q;
  logic            issue_q;
  logic            rd_vld_q;
  logic            hit_q;
  logic            out_valid_q;
  lkvt_pkg::out_t  out_data_q;

  // latched request and hit data
  lkvt_pkg::op_e               op_q;
  logic [lkvt_pkg::KeyW-1:0]   key_q;
  logic [lkvt_pkg::ValueW-1:0] value_q;
  logic [IdxW-1:0]             slot_q;
  logic [lkvt_pkg::ValueW-1:0] hit_val_q;

  logic            in_xfer;
  logic            finish_go;
  logic            is_set;
  logic            key_zero;
  logic            full;
  logic            do_upd;
  logic            do_app;
  logic            rd_en;
  logic            cmp_hit;
  logic            cmp_last;
  logic [CntW-1:0] last_idx;
  logic [CntW-1:0] count_d;
  logic [IdxW-1:0] wr_idx;
  logic [ExtW-1:0] count_ext;
  lkvt_pkg::out_t  result;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // decode of the held request
  assign is_set    = (op_q == lkvt_pkg::OP_SET);
  assign key_zero  = (key_q == '0);
  assign full      = (count_q == CntW'(ENTRIES));
  assign last_idx  = count_q - CntW'(1);
  assign finish_go = (state_q == S_FINISH) && (!out_valid_q || out_ready_i);
  assign do_upd    = finish_go && is_set && !key_zero && hit_q;
  assign do_app    = finish_go && is_set && !key_zero && !hit_q && !full;
  assign wr_idx    = hit_q ? slot_q : count_q[IdxW-1:0];
  assign count_d   = count_q + CntW'(do_app);
  assign count_ext = ExtW'(count_d);

  // scan compare, one entry per cycle behind the read
  assign rd_en    = (state_q == S_SCAN) && issue_q;
  assign cmp_hit  = rd_vld_q && (key_rd_q == key_q);
  assign cmp_last = rd_vld_q && (CntW'(rd_idx_q) == last_idx);

  // result word
  always_comb begin
    result.read_value      = (!is_set && hit_q) ? hit_val_q : '0;
    result.found           = hit_q;
    result.entry_count_out = count_ext[lkvt_pkg::CountW-1:0];
    if (key_zero) begin
      result.status = lkvt_pkg::ST_ZERO_KEY;
    end else if (is_set && !hit_q && full) begin
      result.status = lkvt_pkg::ST_FULL;
    end else begin
      result.status = lkvt_pkg::ST_OK;
    end
  end

  // key memory: written on append only
  always_ff @(posedge clk_i) begin
    if (do_app) begin
      key_mem[wr_idx] <= key_q;
    end
    if (rd_en) begin
      key_rd_q <= key_mem[scan_idx_q];
    end
  end

  // value memory: written on append and on overwrite
  always_ff @(posedge clk_i) begin
    if (do_upd || do_app) begin
      val_mem[wr_idx] <= value_q;
    end
    if (rd_en) begin
      val_rd_q <= val_mem[scan_idx_q];
    end
  end

  // request and hit capture
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q    <= in_data_i.op;
      key_q   <= in_data_i.key;
      value_q <= in_data_i.value;
    end
    if ((state_q == S_SCAN) && cmp_hit) begin
      slot_q    <= rd_idx_q;
      hit_val_q <= val_rd_q;
    end
  end

  // state machine and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      scan_idx_q  <= '0;
      rd_idx_q    <= '0;
      issue_q     <= 1'b0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            hit_q      <= 1'b0;
            scan_idx_q <= '0;
            rd_vld_q   <= 1'b0;
            if ((in_data_i.key == '0) || (count_q == '0)) begin
              issue_q <= 1'b0;
              state_q <= S_FINISH;
            end else begin
              issue_q <= 1'b1;
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          rd_vld_q <= rd_en;
          rd_idx_q <= scan_idx_q;
          if (rd_en) begin
            scan_idx_q <= scan_idx_q + IdxW'(1);
            if (CntW'(scan_idx_q) == last_idx) begin
              issue_q <= 1'b0;
            end
          end
          if (cmp_hit) begin
            hit_q    <= 1'b1;
            issue_q  <= 1'b0;
            rd_vld_q <= 1'b0;
            state_q  <= S_FINISH;
          end else if (cmp_last) begin
            issue_q  <= 1'b0;
            rd_vld_q <= 1'b0;
            state_q  <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (finish_go) begin
            count_q     <= count_d;
            out_valid_q <= 1'b1;
            out_data_q  <= result;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `LKVT_ASSERT(a_count_bound, count_q <= CntW'(ENTRIES))
  `LKVT_ASSERT_IMPL(a_read_in_range, rd_en, CntW'(scan_idx_q) < count_q)
  `LKVT_ASSERT_NEXT(a_zero_key_keeps_count, finish_go && key_zero, count_q == $past(count_q))
  `LKVT_ASSERT_NEXT(a_hit_reports_found, finish_go && hit_q, out_valid_o && out_data_o.found)

endmodule
